@@ hw/rtl/dsf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dsf_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int NUM_DIGITS = 10;
  localparam int FW_W       = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIDX_W     = $clog2(NUM_DIGITS);
  localparam int REV_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_WIDTH  = 3'd0,
    CFG_GROUP_COMMAS = 3'd1,
    CFG_FILL_ZERO    = 3'd2,
    CFG_ALIGN        = 3'd3,
    CFG_SIGN         = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] ALIGN_NONE   = 2'd0;
  localparam logic [1:0] ALIGN_AFTER  = 2'd1;
  localparam logic [1:0] ALIGN_BEFORE = 2'd2;

  localparam logic [1:0] SIGN_MINUS  = 2'd0;
  localparam logic [1:0] SIGN_ALWAYS = 2'd1;
  localparam logic [1:0] SIGN_NEVER  = 2'd2;

  localparam logic [1:0] PHASE_COMMA = 2'd3;

  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic [FW_W-1:0] field_width;
    logic            group_commas;
    logic            fill_with_zero;
    logic [1:0]      align_mode;
    logic [1:0]      sign_mode;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bcd_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_CNT,
    S_PLAN,
    S_EMIT
  } emit_state_t;

  // commas needed for a given digit count
  function automatic logic [1:0] comma_cnt(input logic [REV_W-1:0] nd);
    logic [1:0] c;
    c = 2'd0;
    if (nd >= 4'd10) begin
      c = 2'd3;
    end else if (nd >= 4'd7) begin
      c = 2'd2;
    end else if (nd >= 4'd4) begin
      c = 2'd1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dsf_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dsf_in_if import dsf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dsf_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dsf_out_if import dsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dsf_bcd.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dsf_bcd import dsf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [VALUE_W-1:0]   value,
  output      digit_t [NUM_DIGITS-1:0] digits,
  output      bcd_stat_t            stat
);

  logic [VALUE_W-1:0]      bin_r, bin_nxt;
  logic [4*NUM_DIGITS-1:0] bcd_r, bcd_nxt;
  logic [4*NUM_DIGITS-1:0] adj;
  logic [BIT_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic                    last_bit;

  assign last_bit = busy_r && (cnt_r == BIT_CNT_W'(VALUE_W - 1));

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
      bcd_nxt = {adj[4*NUM_DIGITS-2:0], bin_r[VALUE_W-1]};
      cnt_nxt = cnt_r + BIT_CNT_W'(1);
      if (last_bit) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign digits = bcd_r;
  assign stat   = '{busy: busy_r, done: done_r};

endmodule

`default_nettype wire

@@ hw/rtl/dsf_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dsf_emit import dsf_pkg::*; #(
  parameter int MAX_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic                    start_neg,
  input  wire cfg_t                    cfg,
  input  wire digit_t [NUM_DIGITS-1:0] digits,
  input  wire bcd_stat_t               bcd_stat,
  output      logic                    idle,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      logic [CHAR_W-1:0]       out_char,
  output      logic                    last_char
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int LW = FW_W + 1;

  emit_state_t state_r, state_nxt;

  logic              neg_r, neg_nxt;
  logic [REV_W-1:0]  n_r, n_nxt;
  logic              sign_pend_r, sign_pend_nxt;
  logic [CW-1:0]     pre_r, pre_nxt;
  logic [CW-1:0]     post_r, post_nxt;
  logic [REV_W-1:0]  rem_r, rem_nxt;
  logic [DIDX_W-1:0] didx_r, didx_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              ov_r, ov_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;

  logic              load;
  logic [CHAR_W-1:0] cur_char;
  logic              cur_last;
  logic [CHAR_W-1:0] pad_char;
  logic [REV_W-1:0]  nd;
  logic [LW-1:0]     w, nx, len;
  logic              len_le_n;
  logic [REV_W-1:0]  i0;
  logic [REV_W-1:0]  base;
  logic [1:0]        r0;

  assign load     = (state_r == S_EMIT) && (!ov_r || out_ready);
  assign pad_char = cfg.fill_with_zero ? CH_ZERO : CH_SPACE;

  // digit count
  always_comb begin
    nd = 4'd1;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        nd = REV_W'(i + 1);
      end
    end
  end

  // text length and starting point of the digit walk
  always_comb begin
    w  = ({1'b0, cfg.field_width} > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH)
                                                      : {1'b0, cfg.field_width};
    nx = LW'(n_r);
    if (w == '0) begin
      len = nx;
    end else if (w < nx) begin
      len = w;
    end else if (w > nx && (cfg.align_mode == ALIGN_AFTER ||
                            cfg.align_mode == ALIGN_BEFORE)) begin
      len = w;
    end else begin
      len = nx;
    end
    len_le_n = (len <= nx);
    i0       = len_le_n ? REV_W'(len - LW'(1)) : (n_r - REV_W'(1));
    base     = {i0[3:2], 1'b0} + {2'b00, i0[3:2]};
    r0       = i0[1:0];
  end

  // character at the head of the sequence
  always_comb begin
    if (sign_pend_r) begin
      cur_char = neg_r ? CH_MINUS : CH_PLUS;
      cur_last = (pre_r == '0) && (rem_r == '0) && (post_r == '0);
    end else if (pre_r != '0) begin
      cur_char = pad_char;
      cur_last = (pre_r == CW'(1)) && (rem_r == '0) && (post_r == '0);
    end else if (rem_r != '0) begin
      if (cfg.group_commas && phase_r == PHASE_COMMA) begin
        cur_char = CH_COMMA;
      end else begin
        cur_char = CH_ZERO | {4'd0, digits[didx_r]};
      end
      cur_last = (rem_r == REV_W'(1)) && (post_r == '0);
    end else begin
      cur_char = pad_char;
      cur_last = (post_r == CW'(1));
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (bcd_stat.done) begin
          state_nxt = S_CNT;
        end
      end
      S_CNT:  state_nxt = S_PLAN;
      S_PLAN: state_nxt = S_EMIT;
      S_EMIT: begin
        if (load && cur_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    sign_pend_nxt = sign_pend_r;
    pre_nxt       = pre_r;
    post_nxt      = post_r;
    rem_nxt       = rem_r;
    didx_nxt      = didx_r;
    phase_nxt     = phase_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    ov_nxt        = out_ready ? 1'b0 : ov_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt = start_neg;
        end
      end
      S_CONV: begin
      end
      S_CNT: begin
        n_nxt = nd + (cfg.group_commas ? {2'b00, comma_cnt(nd)} : REV_W'(0));
      end
      S_PLAN: begin
        sign_pend_nxt = (cfg.sign_mode == SIGN_ALWAYS) ||
                        (cfg.sign_mode != SIGN_NEVER && neg_r);
        rem_nxt       = i0 + REV_W'(1);
        pre_nxt       = '0;
        post_nxt      = '0;
        if (!len_le_n) begin
          if (cfg.align_mode == ALIGN_BEFORE) begin
            pre_nxt = CW'(len - nx);
          end else begin
            post_nxt = CW'(len - nx);
          end
        end
        if (cfg.group_commas) begin
          phase_nxt = r0;
          didx_nxt  = DIDX_W'(base + ((r0 == PHASE_COMMA) ? REV_W'(2) : {2'b00, r0}));
        end else begin
          phase_nxt = 2'd0;
          didx_nxt  = DIDX_W'(i0);
        end
      end
      S_EMIT: begin
        if (load) begin
          char_nxt = cur_char;
          last_nxt = cur_last;
          ov_nxt   = 1'b1;
          if (sign_pend_r) begin
            sign_pend_nxt = 1'b0;
          end else if (pre_r != '0) begin
            pre_nxt = pre_r - CW'(1);
          end else if (rem_r != '0) begin
            rem_nxt = rem_r - REV_W'(1);
            if (cfg.group_commas && phase_r == PHASE_COMMA) begin
              phase_nxt = 2'd2;
            end else begin
              didx_nxt  = didx_r - DIDX_W'(1);
              phase_nxt = phase_r - 2'd1;
            end
          end else begin
            post_nxt = post_r - CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ov_r        <= 1'b0;
      sign_pend_r <= 1'b0;
      pre_r       <= '0;
      post_r      <= '0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ov_r        <= ov_nxt;
      sign_pend_r <= sign_pend_nxt;
      pre_r       <= pre_nxt;
      post_r      <= post_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r   <= neg_nxt;
    n_r     <= n_nxt;
    didx_r  <= didx_nxt;
    phase_r <= phase_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_char  = char_r;
  assign last_char = last_r;

endmodule

`default_nettype wire

@@ hw/rtl/decimal_string_formatter.sv @@
// the 32-step serial binary-to-bcd shifter converts the magnitude, S_CNT and S_PLAN
// size the text, and S_EMIT loads it into the one-character output register
// a new request is not taken while one is in flight; it is taken once the last character
// is loaded into the output register and the emitter is back in S_IDLE
// reset: synchronous, active low; clears configuration to 0 and resets the control state
`timescale 1ns / 1ps
`default_nettype none

module decimal_string_formatter import dsf_pkg::*; #(
  parameter int MAX_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  dsf_in_if.sink                     in_chan,
  dsf_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                    cfg_r, cfg_nxt;
  digit_t [NUM_DIGITS-1:0] digits;
  bcd_stat_t               bcd_st;
  logic                    idle;
  logic                    accept;

  assign in_chan.ready = idle;
  assign accept        = in_chan.valid && idle;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIELD_WIDTH:  cfg_nxt.field_width    = cfg_wdata[FW_W-1:0];
        CFG_GROUP_COMMAS: cfg_nxt.group_commas   = cfg_wdata[0];
        CFG_FILL_ZERO:    cfg_nxt.fill_with_zero = cfg_wdata[0];
        CFG_ALIGN:        cfg_nxt.align_mode     = cfg_wdata[1:0];
        CFG_SIGN:         cfg_nxt.sign_mode      = cfg_wdata[1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dsf_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .value  (in_chan.value),
    .digits (digits),
    .stat   (bcd_st)
  );

  dsf_emit #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .start_neg (in_chan.value[VALUE_W-1]),
    .cfg       (cfg_r),
    .digits    (digits),
    .bcd_stat  (bcd_st),
    .idle      (idle),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_char  (out_chan.out_char),
    .last_char (out_chan.last_char)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_chan.ready)
    else $error("request taken while converter still idle");

  a_accept_conv_free: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !bcd_st.busy)
    else $error("request taken during conversion");

  a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_st.done |-> !in_chan.ready)
    else $error("conversion finished with no request in flight");

endmodule

`default_nettype wire

@@ bench/decimal_string_formatter_tb.sv @@
`timescale 1ns / 1ps

module decimal_string_formatter_tb;
  import dsf_pkg::*;

  localparam int TEXT_MAX    = 32;
  localparam int LIMIT       = 1_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int ITEM_GOAL   = 320;
  localparam int TAIL_CYCLES = 60;

  localparam logic [1:0]           ALIGN_SPARE = 2'd3;
  localparam logic [1:0]           SIGN_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dsf_in_if in_chan ();
  dsf_out_if out_chan ();

  decimal_string_formatter #(
    .MAX_WIDTH(TEXT_MAX)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the formatting registers
  logic [FW_W-1:0] cur_width;
  logic            cur_commas;
  logic            cur_fill;
  logic [1:0]      cur_align;
  logic [1:0]      cur_sign;

  logic [VALUE_W-1:0] number_q[$];
  text_char_t         expected_text[$];
  text_char_t         want;

  int  n_queued;
  int  n_taken;
  int  n_chars;
  int  n_errors;
  int  n_settings;
  int  n_cycles;
  int  tx_wait;
  int  rx_wait;
  bit  tx_steady;
  bit  rx_steady;
  bit  hold_go;
  logic rx_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag(input string msg);
    if (n_errors < 40) begin
      $display("mismatch at cycle %0d: %s", n_cycles, msg);
    end
    n_errors++;
  endtask

  function automatic int draw_wait(input bit steady);
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  // characters expected for one number under the current settings
  function automatic void spell_number(input logic [VALUE_W-1:0] raw);
    logic [CHAR_W-1:0]  rev[$];
    logic [CHAR_W-1:0]  text[$];
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  pad;
    logic               neg;
    text_char_t         e;
    int                 ndig;
    int                 n;
    int                 len;
    int                 w;
    neg = raw[VALUE_W-1];
    mag = neg ? (~raw + 1'b1) : raw;
    pad = cur_fill ? CH_ZERO : CH_SPACE;
    ndig = 0;
    do begin
      if (cur_commas && ndig != 0 && ndig % 3 == 0) begin
        rev.push_back(CH_COMMA);
      end
      rev.push_back(CH_ZERO + CHAR_W'(mag % 10));
      mag = mag / 10;
      ndig++;
    end while (mag != 0);
    n = rev.size();
    w = (cur_width > TEXT_MAX) ? TEXT_MAX : int'(cur_width);
    if (w == 0 || (w > n && cur_align != ALIGN_AFTER && cur_align != ALIGN_BEFORE)) begin
      len = n;
    end else begin
      len = w;
    end
    if (cur_sign == SIGN_ALWAYS) begin
      text.push_back(neg ? CH_MINUS : CH_PLUS);
    end else if (cur_sign != SIGN_NEVER && neg) begin
      text.push_back(CH_MINUS);
    end
    if (len > n && cur_align == ALIGN_BEFORE) begin
      repeat (len - n) text.push_back(pad);
    end
    // truncation keeps the lowest characters
    for (int i = (len < n) ? len : n; i > 0; i--) begin
      text.push_back(rev[i-1]);
    end
    if (len > n && cur_align != ALIGN_BEFORE) begin
      repeat (len - n) text.push_back(pad);
    end
    foreach (text[i]) begin
      e.ch = text[i];
      e.last = (i == text.size() - 1);
      expected_text.push_back(e);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] draw_number();
    logic [VALUE_W-1:0] mag;
    int k;
    mag = 1;
    case ($urandom_range(0, 4))
      0: begin
        mag = $urandom();
      end
      1: begin
        mag = $urandom_range(0, 20) - 10;
      end
      2: begin
        // around a power of ten
        k = $urandom_range(0, 9);
        repeat (k) mag = mag * 10;
        mag = mag + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) mag = -mag;
      end
      3: begin
        case ($urandom_range(0, 3))
          0: mag = 32'h8000_0000;
          1: mag = 32'h7fff_ffff;
          2: mag = '0;
          default: mag = '1;
        endcase
      end
      default: begin
        k = $urandom_range(1, 9);
        repeat (k) mag = mag * 10;
        mag = $urandom_range(0, mag - 1);
        if ($urandom_range(0, 1)) mag = -mag;
      end
    endcase
    return mag;
  endfunction

  function automatic logic [FW_W-1:0] draw_width();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return FW_W'(TEXT_MAX);
      2: return '1;
      3: return FW_W'($urandom_range(1, 11));
      4: return FW_W'($urandom_range(12, 31));
      default: return FW_W'($urandom_range(33, 62));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_FIELD_WIDTH:  cur_width = data[FW_W-1:0];
      CFG_GROUP_COMMAS: cur_commas = data[0];
      CFG_FILL_ZERO:    cur_fill = data[0];
      CFG_ALIGN:        cur_align = data[1:0];
      CFG_SIGN:         cur_sign = data[1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [FW_W-1:0] width, input logic commas,
                            input logic fill, input logic [1:0] align,
                            input logic [1:0] sign);
    write_reg(CFG_FIELD_WIDTH, CFG_DATA_W'(width));
    write_reg(CFG_GROUP_COMMAS, CFG_DATA_W'(commas));
    write_reg(CFG_FILL_ZERO, CFG_DATA_W'(fill));
    write_reg(CFG_ALIGN, CFG_DATA_W'(align));
    write_reg(CFG_SIGN, CFG_DATA_W'(sign));
    // no register behind this index
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic push_number(input logic [VALUE_W-1:0] v);
    number_q.push_back(v);
    n_queued++;
  endtask

  task automatic await_drain();
    @(posedge clk);
    while (n_taken != n_queued || expected_text.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      tx_wait = 0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid) begin
        spell_number(in_chan.value);
        n_taken++;
        tx_wait = draw_wait(tx_steady);
      end
      if (tx_wait > 0) begin
        tx_wait--;
        in_chan.valid <= 1'b0;
      end else if (number_q.size() != 0) begin
        in_chan.valid <= 1'b1;
        in_chan.value <= number_q.pop_front();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // character monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        n_chars++;
        if (expected_text.size() == 0) begin
          flag($sformatf("char %02h with nothing pending", out_chan.out_char));
        end else begin
          want = expected_text.pop_front();
          if (out_chan.out_char !== want.ch) begin
            flag($sformatf("char %02h, want %02h", out_chan.out_char, want.ch));
          end
          if (out_chan.last_char !== want.last) begin
            flag($sformatf("last flag %b, want %b", out_chan.last_char, want.last));
          end
        end
        rx_wait = draw_wait(rx_steady);
      end
      if (rx_hold) begin
        out_chan.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT) begin
      $display("timeout with %0d characters pending", expected_text.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int phase;
    int batch;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.value = '0;
    out_chan.ready = 1'b0;
    hold_go = 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    cur_width = '0;
    cur_commas = 1'b0;
    cur_fill = 1'b0;
    cur_align = ALIGN_NONE;
    cur_sign = SIGN_MINUS;
    n_queued = 0;
    n_taken = 0;
    n_chars = 0;
    n_errors = 0;
    n_settings = 0;
    n_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: plain digits
    push_number(0);
    push_number(1);
    push_number(-1);
    push_number(9);
    push_number(10);
    push_number(999);
    push_number(-1000);
    push_number(1000000);
    push_number(2147483647);
    push_number(32'h8000_0000);
    push_number(1234567890);
    await_drain();

    set_config(6'd12, 1'b1, 1'b0, ALIGN_BEFORE, SIGN_ALWAYS);
    push_number(0);
    push_number(32'h8000_0000);
    push_number(1234567);
    await_drain();

    // width above the maximum saturates
    set_config(6'd63, 1'b1, 1'b1, ALIGN_AFTER, SIGN_MINUS);
    push_number(32'h8000_0000);
    push_number(5);
    await_drain();

    // narrow width truncates to the lowest characters
    set_config(6'd3, 1'b1, 1'b0, ALIGN_BEFORE, SIGN_NEVER);
    push_number(-123456);
    push_number(42);
    await_drain();

    set_config(6'd20, 1'b0, 1'b1, ALIGN_SPARE, SIGN_SPARE);
    push_number(-77);
    push_number(1000);
    await_drain();

    // wide width without alignment is ignored
    set_config(6'd32, 1'b0, 1'b1, ALIGN_NONE, SIGN_ALWAYS);
    push_number(-5);
    push_number(0);
    await_drain();

    set_config(6'd1, 1'b1, 1'b1, ALIGN_AFTER, SIGN_NEVER);
    push_number(0);
    push_number(98);
    await_drain();

    phase = 0;
    while (n_queued < ITEM_GOAL) begin
      set_config(draw_width(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        tx_steady = 1'b1;
      end
      batch = $urandom_range(12, 30);
      repeat (batch) push_number(draw_number());
      if (phase == 2) begin
        hold_go = 1'b1;
      end
      await_drain();
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("converted %0d numbers into %0d characters over %0d register settings",
             n_taken, n_chars, n_settings);
    $display("widths 0 to 63, every align and sign code, commas, both fills, long output stall");
    if (n_errors == 0 && expected_text.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
